@@ design/lcdnb_pkg.sv @@
// Shared types, request codes and constants for the character LCD nibble bus writer.
// No dependencies; every other design file imports this package.
`default_nettype none

package lcdnb_pkg;

    localparam int COLUMNS = 16;

    localparam logic [2:0] REQ_CMD    = 3'd0;
    localparam logic [2:0] REQ_DATA   = 3'd1;
    localparam logic [2:0] REQ_SAMPLE = 3'd2;
    localparam logic [2:0] REQ_INIT   = 3'd3;
    localparam logic [2:0] REQ_CURSOR = 3'd4;

    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_HIGH = 2'd1;
    localparam logic [1:0] SP_LOW  = 2'd2;

    localparam logic [2:0] INIT_COUNT = 3'd5;

    localparam logic [5:0] COL_MAX = 6'(COLUMNS - 1);

    localparam logic [7:0] INIT_PIN0 = 8'hFF;
    localparam logic [7:0] INIT_PIN1 = 8'h24;
    localparam logic [7:0] INIT_PIN2 = 8'h20;

    localparam logic [3:0] PH_INIT0 = 4'd0;
    localparam logic [3:0] PH_INIT1 = 4'd1;
    localparam logic [3:0] PH_INIT2 = 4'd2;
    localparam logic [3:0] PH_WR0   = 4'd3;
    localparam logic [3:0] PH_WR1   = 4'd4;
    localparam logic [3:0] PH_WR2   = 4'd5;
    localparam logic [3:0] PH_WR3   = 4'd6;
    localparam logic [3:0] PH_POLL0 = 4'd7;
    localparam logic [3:0] PH_POLL1 = 4'd8;
    localparam logic [3:0] PH_POLL2 = 4'd9;
    localparam logic [3:0] PH_POLL3 = 4'd10;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic       row;
        logic [3:0] col;
        logic [3:0] sampled_nibble;
    } in_t;

    typedef struct packed {
        logic [7:0] port_value;
        logic [1:0] sample_point;
        logic       last;
    } out_t;

    typedef struct packed {
        logic       init;
        logic       wr;
        logic       poll;
        logic [7:0] wbyte;
        logic       rs;
        logic       poll_b3;
    } job_t;

    typedef struct packed {
        logic emit;
        logic pop_q;
    } bk_stat_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h28;
            3'd1:    v = 8'h0C;
            3'd2:    v = 8'h06;
            3'd3:    v = 8'h01;
            3'd4:    v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/lcdnb_front.sv @@
// Request front end: classifies each word, keeps pending byte, busy-wait and init state,
// and pushes a phase job descriptor. Depends on lcdnb_pkg.
`default_nettype none

module lcdnb_front
    import lcdnb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic acc,
    input  wire in_t  req,
    output logic      job_push,
    output job_t      job
);

    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_data_reg, pend_data_next;
    logic       wait_reg, wait_next;
    logic [2:0] step_reg, step_next;
    logic       img_b3_reg, img_b3_next;

    logic [5:0] col_sat;

    always_comb
    begin
        col_sat = ({2'b00, req.col} > COL_MAX) ? COL_MAX : {2'b00, req.col};

        pend_byte_next = pend_byte_reg;
        pend_data_next = pend_data_reg;
        wait_next      = wait_reg;
        step_next      = step_reg;
        img_b3_next    = img_b3_reg;
        job_push       = 1'b0;
        job            = '0;
        job.wbyte      = pend_byte_reg;
        job.rs         = pend_data_reg;

        if (acc)
        begin
            if (req.req_type == REQ_SAMPLE)
            begin
                if (wait_reg)
                begin
                    job_push = 1'b1;
                    if (req.sampled_nibble[3])
                    begin
                        job.poll = 1'b1;
                    end
                    else
                    begin
                        job.wr    = 1'b1;
                        wait_next = 1'b0;
                        if (step_reg != 3'd0)
                        begin
                            if (step_reg < INIT_COUNT)
                            begin
                                pend_byte_next = init_cmd(step_reg);
                                pend_data_next = 1'b0;
                                step_next      = step_reg + 3'd1;
                                job.poll       = 1'b1;
                                wait_next      = 1'b1;
                            end
                            else
                            begin
                                step_next = 3'd0;
                            end
                        end
                    end
                end
            end
            else if (!wait_reg)
            begin
                case (req.req_type)
                    REQ_INIT:
                    begin
                        job_push       = 1'b1;
                        job.init       = 1'b1;
                        job.poll       = 1'b1;
                        pend_byte_next = init_cmd(3'd0);
                        pend_data_next = 1'b0;
                        step_next      = 3'd1;
                        wait_next      = 1'b1;
                    end
                    REQ_CURSOR:
                    begin
                        job_push       = 1'b1;
                        job.poll       = 1'b1;
                        pend_byte_next = {1'b1, req.row, col_sat};
                        pend_data_next = 1'b0;
                        wait_next      = 1'b1;
                    end
                    REQ_CMD, REQ_DATA:
                    begin
                        job_push       = 1'b1;
                        job.poll       = 1'b1;
                        pend_byte_next = req.byte_value;
                        pend_data_next = (req.req_type == REQ_DATA);
                        wait_next      = 1'b1;
                    end
                    default:
                    begin
                        job_push = 1'b0;
                    end
                endcase
            end
        end

        // image bit3 before the poll: init and write phases leave it clear
        job.poll_b3 = (job.init || job.wr) ? 1'b0 : img_b3_reg;
        if (job_push)
        begin
            img_b3_next = job.poll ? job.poll_b3 : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_byte_reg <= '0;
            pend_data_reg <= 1'b0;
            wait_reg      <= 1'b0;
            step_reg      <= '0;
            img_b3_reg    <= 1'b0;
        end
        else
        begin
            pend_byte_reg <= pend_byte_next;
            pend_data_reg <= pend_data_next;
            wait_reg      <= wait_next;
            step_reg      <= step_next;
            img_b3_reg    <= img_b3_next;
        end
    end

endmodule

`default_nettype wire

@@ design/lcdnb_queue.sv @@
// Two-entry job queue between front end and phase sequencer.
// Depends on lcdnb_pkg for the job type.
`default_nettype none

module lcdnb_queue
    import lcdnb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      empty
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic do_wr;
    logic do_rd;

    always_comb
    begin
        full    = (cnt_reg == 2'd2);
        empty   = (cnt_reg == 2'd0);
        rd_data = entry_reg[rd_ptr_reg];
        do_wr   = wr_en && !full;
        do_rd   = rd_en && !empty;

        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/lcdnb_back.sv @@
// Phase sequencer: walks the head job one pin phase per cycle into the result register
// while that register is empty or being popped. Depends on lcdnb_pkg.
`default_nettype none

module lcdnb_back
    import lcdnb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire job_t head,
    output logic      q_pop,
    input  wire logic pop,
    output logic      empty,
    output out_t      result,
    output bk_stat_t  stat
);

    logic       started_reg, started_next;
    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_reg, out_next;

    logic [3:0] start_idx;
    logic [3:0] cur;
    logic [3:0] nxt;
    logic       is_last;
    logic       emit;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] pp;
    out_t       ph;

    always_comb
    begin
        start_idx = head.init ? PH_INIT0 : (head.wr ? PH_WR0 : PH_POLL0);
        cur       = started_reg ? idx_reg : start_idx;

        case (cur)
            PH_INIT2: nxt = head.wr ? PH_WR0 : PH_POLL0;
            default:  nxt = cur + 4'd1;
        endcase

        is_last = (cur == PH_POLL3)
               || (cur == PH_WR3 && !head.poll)
               || (cur == PH_INIT2 && !head.wr && !head.poll);

        hi = {head.wbyte[7:4], 3'b010, head.rs};
        lo = {head.wbyte[3:0], 3'b010, head.rs};
        pp = {4'hF, head.poll_b3, 3'b010};

        ph              = '0;
        ph.sample_point = SP_NONE;
        ph.last         = is_last;
        case (cur)
            PH_INIT0: ph.port_value = INIT_PIN0;
            PH_INIT1: ph.port_value = INIT_PIN1;
            PH_INIT2: ph.port_value = INIT_PIN2;
            PH_WR0:   ph.port_value = hi;
            PH_WR1:   ph.port_value = hi & 8'hFB;
            PH_WR2:   ph.port_value = lo;
            PH_WR3:   ph.port_value = lo & 8'hFB;
            PH_POLL0:
            begin
                ph.port_value   = pp | 8'h04;
                ph.sample_point = SP_HIGH;
            end
            PH_POLL1: ph.port_value = pp;
            PH_POLL2:
            begin
                ph.port_value   = pp | 8'h04;
                ph.sample_point = SP_LOW;
            end
            PH_POLL3: ph.port_value = pp;
            default:  ph.port_value = 8'h00;
        endcase

        emit  = !q_empty && (!out_valid_reg || pop);
        q_pop = emit && is_last;

        started_next   = started_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (emit)
        begin
            out_next       = ph;
            out_valid_next = 1'b1;
            started_next   = !is_last;
            idx_next       = nxt;
        end

        empty      = !out_valid_reg;
        result     = out_reg;
        stat.emit  = emit;
        stat.pop_q = q_pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ design/char_lcd_nibble_bus_writer_core.sv @@
// Top level of the character LCD 4-bit bus writer: front end, job queue, phase sequencer.
// Depends on lcdnb_pkg, lcdnb_front, lcdnb_queue and lcdnb_back.
//
// Usage:
//   Request channel: drive req and raise push; the word is taken on a clock edge
//   with push high and full low. Requests that do nothing (unknown type, busy
//   sample while not polling, anything else while a poll is open) are taken
//   and produce no result.
//   Result channel: while empty is low, result holds the oldest pin phase; it is
//   taken on an edge with pop high. result.last marks the final phase of a request.
//   Path: a taken request goes into the job queue, then its phases pass
//   through the result register. Throughput: one pin phase per cycle out of
//   the sequencer while result is popped or empty; a request expands to 4, 7
//   or 8 phases. A two-entry job queue takes requests while earlier phases drain.
//   Reset: clears pending byte, busy-wait and init state, the queue and the
//   result valid flag. A stalled receiver holds the result register; the queue
//   fills and full rises, and nothing is dropped.
`default_nettype none

module char_lcd_nibble_bus_writer_core
    import lcdnb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire in_t  req,
    input  wire logic pop,
    output logic      empty,
    output out_t      result
);

    logic     acc;
    logic     job_push;
    job_t     job;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    job_t     head;
    bk_stat_t stat;

    assign full = q_full;
    assign acc  = push && !q_full;

    lcdnb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .req      (req),
        .job_push (job_push),
        .job      (job)
    );

    lcdnb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (head),
        .empty   (q_empty)
    );

    lcdnb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .stat    (stat)
    );

`ifndef SYNTHESIS
    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        stat.emit |=> !empty)
        else $error("emitted phase not presented");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop_q |-> !q_empty)
        else $error("job retired from empty queue");

    a_sample_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.sample_point <= SP_LOW))
        else $error("bad sample point code");

    a_poll_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.sample_point != SP_NONE) |-> result.port_value[1])
        else $error("sample point outside a read phase");
`endif

endmodule

`default_nettype wire

@@ tb/char_lcd_nibble_bus_writer_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for char_lcd_nibble_bus_writer_core: sends LCD bus requests, predicts the pin
// phases each one expands to and checks every result word in order, field by field.
// Depends on lcdnb_pkg and the core RTL.

module char_lcd_nibble_bus_writer_core_tb;
    import lcdnb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;
    localparam int IN_W = $bits(in_t);

    localparam logic [7:0] PIN_EN     = 8'h04;
    localparam logic [7:0] PIN_RW     = 8'h02;
    localparam logic [7:0] PIN_RS     = 8'h01;
    localparam logic [7:0] DATA_HI    = 8'hF0;
    localparam logic [7:0] POLL_KEEP  = 8'hF8;
    localparam logic [7:0] LINE0_ADDR = 8'h80;
    localparam logic [7:0] LINE1_ADDR = 8'hC0;

    localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

    function automatic logic [7:0] init_seq(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h28;
            3'd1:    v = 8'h0C;
            3'd2:    v = 8'h06;
            3'd3:    v = 8'h01;
            3'd4:    v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    logic clk;
    logic rst_n;
    logic push;
    logic pop;
    logic full;
    logic empty;
    in_t  req;
    out_t result;

    logic [7:0] pin_image;
    logic [7:0] pend_byte;
    logic       pend_rs;
    logic       poll_open;
    logic [2:0] init_pos;

    out_t expected_phases[$];
    out_t step_phases[$];
    out_t want_phase;

    int err_count = 0;
    int cycle_count = 0;
    int busy_words = 0;
    int tx_gap_pct = 25;
    int rx_gap_pct = 25;

    char_lcd_nibble_bus_writer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .req    (req),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
            begin
                $display("MISMATCH @%0t: %s", $realtime, msg);
            end
        end
    endtask

    task automatic add_phase(input logic [7:0] pins, input logic [1:0] sp);
        out_t ph;
        begin
            pin_image = pins;
            ph.port_value = pins;
            ph.sample_point = sp;
            ph.last = 1'b0;
            step_phases.push_back(ph);
        end
    endtask

    task automatic add_poll();
        logic [7:0] p;
        begin
            p = ((pin_image | DATA_HI) & POLL_KEEP) | PIN_RW;
            add_phase(p | PIN_EN, SP_HIGH);
            add_phase(p, SP_NONE);
            add_phase(p | PIN_EN, SP_LOW);
            add_phase(p, SP_NONE);
            poll_open = 1'b1;
        end
    endtask

    task automatic add_write();
        logic [7:0] rs;
        logic [7:0] hi;
        logic [7:0] lo;
        begin
            rs = pend_rs ? PIN_RS : 8'h00;
            hi = (pend_byte & DATA_HI) | PIN_EN | rs;
            lo = {pend_byte[3:0], 4'h0} | PIN_EN | rs;
            add_phase(hi, SP_NONE);
            add_phase(hi & ~PIN_EN, SP_NONE);
            add_phase(lo, SP_NONE);
            add_phase(lo & ~PIN_EN, SP_NONE);
            poll_open = 1'b0;
        end
    endtask

    task automatic predict_phases(input in_t w);
        logic [3:0] col_sat;
        begin
            step_phases.delete();
            if (w.req_type == REQ_SAMPLE)
            begin
                if (poll_open)
                begin
                    if (w.sampled_nibble[3])
                    begin
                        add_poll();
                    end
                    else
                    begin
                        add_write();
                        if (init_pos != '0)
                        begin
                            if (init_pos < INIT_COUNT)
                            begin
                                pend_byte = init_seq(init_pos);
                                pend_rs = 1'b0;
                                init_pos = init_pos + 3'd1;
                                add_poll();
                            end
                            else
                            begin
                                init_pos = '0;
                            end
                        end
                    end
                end
            end
            else if (w.req_type <= REQ_CURSOR && !poll_open)
            begin
                if (w.req_type == REQ_INIT)
                begin
                    add_phase(INIT_PIN0, SP_NONE);
                    add_phase(INIT_PIN1, SP_NONE);
                    add_phase(INIT_PIN2, SP_NONE);
                    pend_byte = init_seq(3'd0);
                    pend_rs = 1'b0;
                    init_pos = 3'd1;
                end
                else if (w.req_type == REQ_CURSOR)
                begin
                    col_sat = (w.col > COL_MAX) ? COL_MAX[3:0] : w.col;
                    pend_byte = (w.row ? LINE1_ADDR : LINE0_ADDR) | {4'h0, col_sat};
                    pend_rs = 1'b0;
                end
                else
                begin
                    pend_byte = w.byte_value;
                    pend_rs = (w.req_type == REQ_DATA);
                end
                add_poll();
            end
            if (step_phases.size() != 0)
            begin
                step_phases[step_phases.size() - 1].last = 1'b1;
                busy_words++;
            end
            foreach (step_phases[i])
            begin
                expected_phases.push_back(step_phases[i]);
            end
        end
    endtask

    function automatic in_t make_word(input logic [2:0] t, input logic [7:0] b,
                                      input logic r, input logic [3:0] c,
                                      input logic [3:0] s);
        in_t w;
        w.req_type = t;
        w.byte_value = b;
        w.row = r;
        w.col = c;
        w.sampled_nibble = s;
        return w;
    endfunction

    function automatic logic [2:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return REQ_CMD;
        else if (r < 65)
            return REQ_DATA;
        else if (r < 85)
            return REQ_CURSOR;
        else
            return REQ_INIT;
    endfunction

    task automatic send_word(input in_t w);
        begin
            req <= w;
            push <= 1'b1;
            @(posedge clk);
            while (full)
                @(posedge clk);
            predict_phases(w);
        end
    endtask

    task automatic maybe_idle();
        begin
            if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    task automatic send_and_gap(input in_t w);
        begin
            send_word(w);
            maybe_idle();
        end
    endtask

    task automatic wait_for_drain();
        begin
            push <= 1'b0;
            @(posedge clk);
            while (expected_phases.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_directed_cases();
        begin
            // ignored while idle: stray sample and unused codes
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_UNUSED_HI, 8'hFF, 1'b1, 4'hF, 4'hF));
            send_and_gap(make_word(REQ_UNUSED_LO, 8'h5A, 1'b0, 4'h5, 4'hA));
            // command with a busy retry and a request dropped mid-poll
            send_and_gap(make_word(REQ_CMD, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'hFF, 1'b1, 4'hF, 4'hF));
            send_and_gap(make_word(REQ_CMD, 8'h33, 1'b1, 4'hC, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_DATA, 8'hFF, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h7));
            send_and_gap(make_word(REQ_DATA, 8'hA5, 1'b1, 4'h3, 4'h0));
            send_and_gap(make_word(REQ_UNUSED_MID, 8'h11, 1'b0, 4'h1, 4'h1));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h8));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h3));
            send_and_gap(make_word(REQ_CURSOR, 8'hFF, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_CURSOR, 8'h00, 1'b1, 4'hF, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h6));
            // full init run, with a second init dropped and one busy retry
            send_and_gap(make_word(REQ_INIT, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_INIT, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h9));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
            send_and_gap(make_word(REQ_SAMPLE, 8'h00, 1'b0, 4'h0, 4'h0));
        end
    endtask

    task automatic test_random_traffic(input int goal, input bit vary_gaps);
        int stop_at;
        in_t w;
        begin
            stop_at = busy_words + goal;
            while (busy_words < stop_at)
            begin
                if (vary_gaps && $urandom_range(0, 39) == 0)
                begin
                    tx_gap_pct = 10 * $urandom_range(0, 4);
                    rx_gap_pct = 10 * $urandom_range(0, 4);
                end
                w = in_t'(IN_W'($urandom));
                if ($urandom_range(0, 9) == 0)
                begin
                    if (w.req_type <= REQ_CURSOR)
                        w.req_type = REQ_SAMPLE;
                    send_and_gap(w);
                end
                else
                begin
                    w.req_type = pick_request();
                    send_and_gap(w);
                    while (poll_open)
                    begin
                        w = in_t'(IN_W'($urandom));
                        if ($urandom_range(0, 9) == 0)
                        begin
                            if (w.req_type == REQ_SAMPLE)
                                w.req_type = REQ_CMD;
                        end
                        else
                        begin
                            w.req_type = REQ_SAMPLE;
                            w.sampled_nibble[3] = ($urandom_range(0, 99) < 30);
                        end
                        send_and_gap(w);
                    end
                end
            end
        end
    endtask

    task automatic test_restart_after_drain();
        begin
            wait_for_drain();
            test_random_traffic(12, 1'b0);
        end
    endtask

    task automatic test_back_to_back();
        begin
            tx_gap_pct = 0;
            rx_gap_pct = 0;
            test_random_traffic(60, 1'b0);
        end
    endtask

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_phases.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word port=%02h sp=%0d last=%0b",
                                          result.port_value, result.sample_point,
                                          result.last));
            end
            else
            begin
                want_phase = expected_phases.pop_front();
                if (result.port_value !== want_phase.port_value)
                    report_mismatch($sformatf("port_value got %02h want %02h",
                                              result.port_value, want_phase.port_value));
                if (result.sample_point !== want_phase.sample_point)
                    report_mismatch($sformatf("sample_point got %0d want %0d",
                                              result.sample_point, want_phase.sample_point));
                if (result.last !== want_phase.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              result.last, want_phase.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        req = '0;
        pin_image = '0;
        pend_byte = '0;
        pend_rs = 1'b0;
        poll_open = 1'b0;
        init_pos = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(125, 1'b1);
        test_restart_after_drain();
        test_random_traffic(125, 1'b1);
        test_back_to_back();
        wait_for_drain();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/lcdnb_pkg.sv
design/lcdnb_front.sv
design/lcdnb_queue.sv
design/lcdnb_back.sv
design/char_lcd_nibble_bus_writer_core.sv
tb/char_lcd_nibble_bus_writer_core_tb.sv
